// ----- rtl/core/line_substring_matcher_unit_assert.svh -----
// Assertion macros for the line substring matcher.
`ifndef LINE_SUBSTRING_MATCHER_UNIT_ASSERT_SVH
`define LINE_SUBSTRING_MATCHER_UNIT_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define LSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line matcher check failed");

// Condition in this cycle implies a consequence in the next cycle.
`define LSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line matcher check failed");

`endif

// ----- rtl/core/lsm_pkg.sv -----
// Package with types, constants and helpers of the line substring matcher.
`default_nettype none

package lsm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;
   localparam int PATTERN_WORDS       = 4;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 64;
   localparam int PATTERN_LEN_W       = 6;
   localparam int LINE_NUM_W          = 32;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] UPPER_A      = 8'h41;
   localparam logic [7:0] UPPER_Z      = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LEN    = 3'd0,
      CSR_IGNORE_CASE    = 3'd1,
      CSR_INVERT         = 3'd2,
      CSR_PATTERN_WORD_0 = 3'd3,
      CSR_PATTERN_WORD_1 = 3'd4,
      CSR_PATTERN_WORD_2 = 3'd5,
      CSR_PATTERN_WORD_3 = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_file;
   } req_payload_type;

   typedef struct packed {
      logic [LINE_NUM_W-1:0] line_no;
      logic                  selected;
   } rsp_payload_type;

   // ASCII-only lower-case fold
   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold_en);
      logic [7:0] r;
      r = c;
      if (fold_en && c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/line_substring_matcher_unit.sv -----
// Top level of the line substring matcher: fixed-string per-line match.
`default_nettype none

// Streams text one byte per word and reports, at each line end (newline byte or
// a byte flagged end_of_file), the line number within the file and whether the
// line is selected: it holds the configured pattern (up to PATTERN_MAX bytes,
// optional ASCII case folding, cut at the first zero pattern byte, empty
// pattern matches all), flipped by invert. A zero text byte stops matching for
// the rest of its line. Line numbers start at 1 per file and saturate. Rate:
// one byte per cycle while results are taken; a byte is held in the input
// register, then the whole window compare (the newest PATTERN_MAX bytes against
// the pattern aligned to the effective length) runs in a single pass into the
// result register as the input register takes another byte.
// While a result waits on rsp_ready the input register can still take one
// byte, which then holds there; further input stalls until the result is
// taken. Configuration must be written only while idle; the block does not
// enforce this. It acts on the next byte compared.
module line_substring_matcher_unit #(
   parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lsm_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lsm_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [lsm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lsm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lsm_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   // configuration registers
   logic [PATTERN_LEN_W-1:0]                 pattern_len_ff, pattern_len_in;
   logic                                     ignore_case_ff, ignore_case_in;
   logic                                     invert_ff, invert_in;
   logic [PATTERN_WORDS-1:0][CSR_DATA_W-1:0] pattern_word_ff, pattern_word_in;

   // input register
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff, s1_data_in;

   // per-line state; history is newest first
   logic [7:0]            hist_ff [PATTERN_MAX];
   logic [7:0]            hist_in [PATTERN_MAX];
   logic                  found_ff, found_in;
   logic                  stopped_ff, stopped_in;
   logic [LINE_NUM_W-1:0] line_count_ff, line_count_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // datapath
   logic [7:0]            pat_byte [PATTERN_MAX];
   logic [7:0]            hist_shift [PATTERN_MAX];
   logic [LEN_W-1:0]      len_cap;
   logic [LEN_W-1:0]      eff_len;
   logic                  window_hit;
   logic                  rsp_free;
   logic                  consume;
   logic                  line_end;
   logic                  byte_taken;
   logic                  found_now;
   logic [LINE_NUM_W-1:0] line_num_next;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign consume   = s1_valid_ff && rsp_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // pattern bytes, byte 0 in the low bits of word 0
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pat_byte[i] = pattern_word_ff[i >> 3][(i & 7) * 8 +: 8];
      end
   end

   // effective length: capped, then cut at the first zero pattern byte
   always_comb begin
      if (pattern_len_ff > PATTERN_LEN_W'(PATTERN_MAX)) begin
         len_cap = LEN_W'(PATTERN_MAX);
      end else begin
         len_cap = LEN_W'(pattern_len_ff);
      end
      eff_len = len_cap;
      for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
         if (LEN_W'(i) < len_cap && pat_byte[i] == 8'd0) begin
            eff_len = LEN_W'(i);
         end
      end
   end

   // history after taking the current byte
   always_comb begin
      hist_shift[0] = s1_data_ff.text_byte;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         hist_shift[j] = hist_ff[j-1];
      end
   end

   // window compare: hist_shift[j] lines up with pattern byte eff_len-1-j.
   // Short lines fail on their own since the cleared history holds zeros.
   always_comb begin
      logic [LEN_W-1:0] pos;
      window_hit = (eff_len != '0);
      for (int j = 0; j < PATTERN_MAX; j++) begin
         pos = eff_len - LEN_W'(j) - LEN_W'(1);
         if (LEN_W'(j) < eff_len) begin
            if (fold_char(hist_shift[j], ignore_case_ff) !=
                fold_char(pat_byte[pos[IDX_W-1:0]], ignore_case_ff)) begin
               window_hit = 1'b0;
            end
         end
      end
   end

   assign byte_taken = !stopped_ff && (s1_data_ff.text_byte != 8'd0);
   assign found_now  = found_ff || (byte_taken && window_hit);
   assign line_end   = (s1_data_ff.text_byte == NEWLINE_CHAR) || s1_data_ff.end_of_file;
   assign line_num_next = (line_count_ff == '1) ? line_count_ff
                                                : line_count_ff + LINE_NUM_W'(1);

   always_comb begin
      pattern_len_in  = pattern_len_ff;
      ignore_case_in  = ignore_case_ff;
      invert_in       = invert_ff;
      pattern_word_in = pattern_word_ff;
      s1_valid_in     = s1_valid_ff;
      s1_data_in      = s1_data_ff;
      hist_in         = hist_ff;
      found_in        = found_ff;
      stopped_in      = stopped_ff;
      line_count_in   = line_count_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            CSR_PATTERN_LEN:    pattern_len_in     = csr_wdata[PATTERN_LEN_W-1:0];
            CSR_IGNORE_CASE:    ignore_case_in     = csr_wdata[0];
            CSR_INVERT:         invert_in          = csr_wdata[0];
            CSR_PATTERN_WORD_0: pattern_word_in[0] = csr_wdata;
            CSR_PATTERN_WORD_1: pattern_word_in[1] = csr_wdata;
            CSR_PATTERN_WORD_2: pattern_word_in[2] = csr_wdata;
            CSR_PATTERN_WORD_3: pattern_word_in[3] = csr_wdata;
            default: ;
         endcase
      end

      // input register
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_payload;
      end else if (consume) begin
         s1_valid_in = 1'b0;
      end

      // result register drains
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (consume) begin
         if (!stopped_ff) begin
            if (s1_data_ff.text_byte == 8'd0) begin
               stopped_in = 1'b1;
            end else begin
               hist_in  = hist_shift;
               found_in = found_now;
            end
         end
         if (line_end) begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.line_no   = line_num_next;
            rsp_data_in.selected  = (found_now || eff_len == '0) ^ invert_ff;
            for (int j = 0; j < PATTERN_MAX; j++) begin
               hist_in[j] = 8'd0;
            end
            found_in      = 1'b0;
            stopped_in    = 1'b0;
            line_count_in = s1_data_ff.end_of_file ? '0 : line_num_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff  <= '0;
         ignore_case_ff  <= 1'b0;
         invert_ff       <= 1'b0;
         pattern_word_ff <= '0;
         s1_valid_ff     <= 1'b0;
         for (int j = 0; j < PATTERN_MAX; j++) begin
            hist_ff[j] <= 8'd0;
         end
         found_ff        <= 1'b0;
         stopped_ff      <= 1'b0;
         line_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pattern_len_ff  <= pattern_len_in;
         ignore_case_ff  <= ignore_case_in;
         invert_ff       <= invert_in;
         pattern_word_ff <= pattern_word_in;
         s1_valid_ff     <= s1_valid_in;
         hist_ff         <= hist_in;
         found_ff        <= found_in;
         stopped_ff      <= stopped_in;
         line_count_ff   <= line_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

`include "line_substring_matcher_unit_assert.svh"

   // a byte that does not end its line leaves no result behind
   `LSM_ASSERT_NEXT(a_no_result_mid_line, clock, reset, consume && !line_end, !rsp_valid_ff)
   // end of file restarts the line count
   `LSM_ASSERT_NEXT(a_eof_restarts_count, clock, reset,
                    consume && s1_data_ff.end_of_file, line_count_ff == '0)
   // line end clears the per-line state
   `LSM_ASSERT_NEXT(a_line_state_cleared, clock, reset, consume && line_end,
                    !found_ff && !stopped_ff && hist_ff[0] == 8'd0)
   // reported line numbers start at one
   `LSM_ASSERT_SAME(a_line_number_nonzero, clock, reset, rsp_valid_ff,
                    rsp_data_ff.line_no != '0)

endmodule

`default_nettype wire
